@@ hdl/mbe_pkg.sv @@
package mbe_pkg;

  // Coordinate format: signed, FRAC_BITS fraction bits
  localparam int COORD_WIDTH = 32;
  localparam int FRAC_BITS   = 28;

  // Iterate width: at least 8 integer bits plus sign, and room for z^2 + c
  localparam int Z_WIDTH = (FRAC_BITS + 9 > COORD_WIDTH + 2) ? FRAC_BITS + 9 : COORD_WIDTH + 2;
  // Multiplier operand: |z| <= 2.0 when multiplied
  localparam int MUL_WIDTH  = FRAC_BITS + 3;
  localparam int PROD_WIDTH = 2 * MUL_WIDTH;

  // Dwell counter and limit register
  localparam int CNT_WIDTH = 16;
  localparam logic [CNT_WIDTH-1:0] MAX_ITER_RESET = CNT_WIDTH'(1200);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_UPDATE,
    ST_FINISH
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic load;      // capture c, z = c, count = 0
    logic mul_en;    // register the three products
    logic upd;       // z = z^2 + c, count + 1
    logic out_load;  // move count into the output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic at_limit;   // count reached max_iterations
    logic out_range;  // a component of z is beyond +-2
    logic escape;     // |z|^2 > 4
  } status_t;

endpackage

@@ hdl/mbe_point_if.sv @@
interface mbe_point_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [mbe_pkg::COORD_WIDTH-1:0] point_real;
  logic signed [mbe_pkg::COORD_WIDTH-1:0] point_imag;

  modport source (output valid, output point_real, output point_imag, input ready);
  modport sink   (input valid, input point_real, input point_imag, output ready);
endinterface

@@ hdl/mbe_count_if.sv @@
interface mbe_count_if;
  logic                             valid;
  logic                             ready;
  logic [mbe_pkg::CNT_WIDTH-1:0]    escape_count;

  modport source (output valid, output escape_count, input ready);
  modport sink   (input valid, input escape_count, output ready);
endinterface

@@ hdl/mbe_datapath.sv @@
module mbe_datapath (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  mbe_pkg::cmd_t                          cmd_i,
  output mbe_pkg::status_t                       status_o,
  input  logic signed [mbe_pkg::COORD_WIDTH-1:0] point_real_i,
  input  logic signed [mbe_pkg::COORD_WIDTH-1:0] point_imag_i,
  input  logic                                   cfg_we_i,
  input  logic [mbe_pkg::CNT_WIDTH-1:0]          cfg_wdata_i,
  output logic [mbe_pkg::CNT_WIDTH-1:0]          escape_count_o
);

  localparam int ZW  = mbe_pkg::Z_WIDTH;
  localparam int CW  = mbe_pkg::COORD_WIDTH;
  localparam int F   = mbe_pkg::FRAC_BITS;
  localparam int MW  = mbe_pkg::MUL_WIDTH;
  localparam int PW  = mbe_pkg::PROD_WIDTH;
  localparam int NW  = mbe_pkg::CNT_WIDTH;
  localparam int SQW = PW - F;       // floor(z^2 / 2^F)
  localparam int XW  = PW - F + 1;   // floor(2 zr zi / 2^F)

  localparam logic signed [ZW-1:0]    TWO_Z  = ZW'(2) <<< F;
  localparam logic signed [ZW-1:0]    MTWO_Z = -(ZW'(2) <<< F);
  localparam logic signed [SQW:0]     FOUR_S = (SQW + 1)'(4) <<< F;

  logic signed [ZW-1:0]  c_re_q, c_im_q, z_re_q, z_re_d, z_im_q, z_im_d;
  logic signed [PW-1:0]  p_rr_q, p_ii_q, p_ri_q;
  logic signed [MW-1:0]  op_re, op_im;
  logic signed [PW-1:0]  prod_rr, prod_ii, prod_ri;
  logic signed [SQW-1:0] sq_re, sq_im;
  logic signed [SQW:0]   mag_sum;
  logic signed [XW-1:0]  cross_term;
  logic [NW-1:0]         iter_q, max_iter_q, count_q;

  // Dwell limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_iter_q <= mbe_pkg::MAX_ITER_RESET;
    end else if (cfg_we_i) begin
      max_iter_q <= cfg_wdata_i;
    end
  end

  // Products; operands fit MW bits whenever the range check passes
  assign op_re   = z_re_q[MW-1:0];
  assign op_im   = z_im_q[MW-1:0];
  assign prod_rr = op_re * op_re;
  assign prod_ii = op_im * op_im;
  assign prod_ri = op_re * op_im;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      p_rr_q <= prod_rr;
      p_ii_q <= prod_ii;
      p_ri_q <= prod_ri;
    end
  end

  // Floor rounding is an arithmetic shift of the exact product
  assign sq_re      = p_rr_q[PW-1:F];
  assign sq_im      = p_ii_q[PW-1:F];
  assign cross_term = p_ri_q[PW-1:F-1];
  assign mag_sum    = {sq_re[SQW-1], sq_re} + {sq_im[SQW-1], sq_im};

  assign z_re_d = {{(ZW-SQW){sq_re[SQW-1]}}, sq_re}
                - {{(ZW-SQW){sq_im[SQW-1]}}, sq_im} + c_re_q;
  assign z_im_d = {{(ZW-XW){cross_term[XW-1]}}, cross_term} + c_im_q;

  // Iterate, point and pass counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iter_q <= '0;
    end else if (cmd_i.load) begin
      iter_q <= '0;
    end else if (cmd_i.upd) begin
      iter_q <= iter_q + NW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      c_re_q <= {{(ZW-CW){point_real_i[CW-1]}}, point_real_i};
      c_im_q <= {{(ZW-CW){point_imag_i[CW-1]}}, point_imag_i};
      z_re_q <= {{(ZW-CW){point_real_i[CW-1]}}, point_real_i};
      z_im_q <= {{(ZW-CW){point_imag_i[CW-1]}}, point_imag_i};
    end else if (cmd_i.upd) begin
      z_re_q <= z_re_d;
      z_im_q <= z_im_d;
    end
  end

  // Output word register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      count_q <= iter_q;
    end
  end

  assign escape_count_o     = count_q;
  assign status_o.at_limit  = (iter_q == max_iter_q);
  assign status_o.out_range = (z_re_q > TWO_Z) || (z_re_q < MTWO_Z) ||
                              (z_im_q > TWO_Z) || (z_im_q < MTWO_Z);
  assign status_o.escape    = (mag_sum > FOUR_S);

endmodule

@@ hdl/mbe_ctrl.sv @@
module mbe_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  mbe_pkg::status_t status_i,
  output mbe_pkg::cmd_t    cmd_o
);

  mbe_pkg::state_e state_q, state_d;
  logic            out_valid_q, out_valid_d;

  // State and output-valid registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mbe_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      mbe_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = mbe_pkg::ST_CHECK;
        end
      end
      mbe_pkg::ST_CHECK: begin
        if (status_i.at_limit || status_i.out_range) begin
          state_d = mbe_pkg::ST_FINISH;
        end else begin
          cmd_o.mul_en = 1'b1;
          state_d      = mbe_pkg::ST_UPDATE;
        end
      end
      mbe_pkg::ST_UPDATE: begin
        if (status_i.escape) begin
          state_d = mbe_pkg::ST_FINISH;
        end else begin
          cmd_o.upd = 1'b1;
          state_d   = mbe_pkg::ST_CHECK;
        end
      end
      mbe_pkg::ST_FINISH: begin
        // wait for the output register to free up
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = mbe_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = mbe_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ hdl/mandelbrot_escape_time.sv @@
// Mandelbrot escape-time unit.
// Each pass is a multiply step (ST_CHECK) and an update step (ST_UPDATE); the loop
// ends in ST_CHECK at the limit or out of range, or in ST_UPDATE when |z|^2 > 4.
// The next point is taken only after the count word enters the output register.
// A finished count waits in the output register while the next point is taken.
// Reset (rst_ni, async, active low): idle, no word pending, max_iterations = 1200.
module mandelbrot_escape_time (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  mbe_point_if.sink                     point_i,
  mbe_count_if.source                   count_o,
  input  logic                          cfg_we_i,
  input  logic [mbe_pkg::CNT_WIDTH-1:0] cfg_wdata_i
);

  mbe_pkg::cmd_t    cmd;
  mbe_pkg::status_t status;

  mbe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (point_i.valid),
    .in_ready_o  (point_i.ready),
    .out_valid_o (count_o.valid),
    .out_ready_i (count_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  mbe_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .point_real_i   (point_i.point_real),
    .point_imag_i   (point_i.point_imag),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .escape_count_o (count_o.escape_count)
  );

  // At most one command per cycle
  a_cmd_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.load, cmd.mul_en, cmd.upd, cmd.out_load}))
    else $error("more than one datapath command");

  // No multiply once z is out of range or the count hit the limit
  a_mul_guard: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.mul_en |-> !status.at_limit && !status.out_range)
    else $error("multiply issued past limit or range");

  // One point in flight: not ready right after an accept
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    point_i.valid && point_i.ready |=> !point_i.ready)
    else $error("point accepted while busy");

  // Loading the output register raises valid next cycle
  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |=> count_o.valid)
    else $error("count word lost");

endmodule

@@ dv/mandelbrot_escape_time_tb.sv @@
`timescale 1ns / 100ps

module mandelbrot_escape_time_tb;

  typedef logic signed [mbe_pkg::COORD_WIDTH-1:0] coord_t;
  typedef logic [mbe_pkg::CNT_WIDTH-1:0]          count_t;

  // One point in flight and the count it should come back with
  typedef struct packed {
    coord_t re;
    coord_t im;
    count_t count;
  } dwell_entry_t;

  localparam longint FX_ONE = longint'(1) << mbe_pkg::FRAC_BITS;

  logic   clk_i  = 1'b0;
  logic   rst_ni = 1'b0;
  logic   cfg_we_i;
  count_t cfg_wdata_i;

  mbe_point_if point_if();
  mbe_count_if count_if();

  mandelbrot_escape_time DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .point_i    (point_if),
    .count_o    (count_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  dwell_entry_t counts_due[$];
  dwell_entry_t seen_due;
  count_t       limit_model;
  int           error_count = 0;
  bit           gaps_on   = 1'b1;
  bit           stalls_on = 1'b1;

  always #1 clk_i = ~clk_i;

  // Hard stop in case the block hangs
  initial begin
    #10_000_000;
    $display("mandelbrot_escape_time_tb: done, errors");
    $finish;
  end

  task automatic note_error(input string msg);
    error_count++;
    if (error_count <= 10) $display("ERROR at %0t: %s", $time, msg);
  endtask

  // Escape-time count of c under the given dwell limit, z starting at c
  function automatic count_t escape_time(input coord_t re, input coord_t im, input count_t lim);
    longint      c_re = re;
    longint      c_im = im;
    longint      z_re = re;
    longint      z_im = im;
    longint      two_fx = longint'(2) << mbe_pkg::FRAC_BITS;
    longint      four_fx = longint'(4) << mbe_pkg::FRAC_BITS;
    longint      sq_re, sq_im, cross_fx;
    int unsigned n = 0;
    while (n < lim) begin
      // a component beyond +-2 escapes without multiplying
      if (z_re > two_fx || z_re < -two_fx || z_im > two_fx || z_im < -two_fx) break;
      // products floored to FRAC_BITS fraction bits
      sq_re = (z_re * z_re) >>> mbe_pkg::FRAC_BITS;
      sq_im = (z_im * z_im) >>> mbe_pkg::FRAC_BITS;
      if (sq_re + sq_im > four_fx) break;
      cross_fx = (z_re * z_im) >>> (mbe_pkg::FRAC_BITS - 1);
      z_re     = sq_re - sq_im + c_re;
      z_im     = cross_fx + c_im;
      n++;
    end
    return count_t'(n);
  endfunction

  function automatic coord_t rand_span(input longint lo, input longint span);
    return coord_t'(lo + longint'($urandom_range(32'(span))));
  endfunction

  // Offer one point; returns at the edge where it is taken
  task automatic send_point(input coord_t re, input coord_t im);
    if (gaps_on) begin
      while ($urandom_range(99) < 24) begin
        point_if.valid <= 1'b0;
        @(posedge clk_i);
      end
    end
    point_if.valid      <= 1'b1;
    point_if.point_real <= re;
    point_if.point_imag <= im;
    @(posedge clk_i);
    while (!point_if.ready) @(posedge clk_i);
    counts_due.push_back('{re, im, escape_time(re, im, limit_model)});
  endtask

  // Hold off the sender until every count word is back
  task automatic wait_drained();
    point_if.valid <= 1'b0;
    do @(posedge clk_i); while (counts_due.size() != 0);
  endtask

  task automatic set_limit(input count_t lim);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= lim;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    limit_model = lim;
  endtask

  // Count word checker and ready driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (count_if.valid && count_if.ready) begin
        if (counts_due.size() == 0) begin
          note_error($sformatf("count word %0d with no point pending", count_if.escape_count));
        end else begin
          seen_due = counts_due.pop_front();
          if (count_if.escape_count !== seen_due.count)
            note_error($sformatf("point (%h, %h): expected %0d, got %0d",
                                 seen_due.re, seen_due.im, seen_due.count,
                                 count_if.escape_count));
        end
      end
      count_if.ready <= (stalls_on && $urandom_range(99) < 24) ? 1'b0 : 1'b1;
    end else begin
      count_if.ready <= 1'b0;
    end
  end

  // Edge points under the reset dwell limit
  task automatic test_reset_limit();
    send_point(0, 0);
    send_point(coord_t'(-FX_ONE), 0);
    send_point(0, coord_t'(FX_ONE));
    send_point(coord_t'(-2 * FX_ONE), 0);          // tip of the set, stays at 2
    send_point(coord_t'(2 * FX_ONE), 0);           // |z|^2 exactly 4 on the first pass
    send_point(coord_t'(2 * FX_ONE + 1), 0);       // just beyond the range check
    send_point(0, coord_t'(2 * FX_ONE));
    send_point(0, coord_t'(-2 * FX_ONE - 1));
    send_point(32'sh8000_0000, 32'sh8000_0000);
    send_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    send_point(32'sh8000_0000, 0);
    send_point(0, 32'sh7FFF_FFFF);
    send_point(coord_t'(3 * FX_ONE / 2), coord_t'(3 * FX_ONE / 2));  // in range, |z|^2 > 4
    send_point(coord_t'(FX_ONE / 4), 0);           // cusp
    send_point(coord_t'(FX_ONE / 4 + FX_ONE / 64), 0);
    send_point(coord_t'(-3 * FX_ONE / 4 + 1), coord_t'(FX_ONE / 10 + 3));
    send_point(-1, -1);
  endtask

  // Dwell limit at zero, one and full scale
  task automatic test_limit_extremes();
    set_limit('0);
    send_point(0, 0);
    send_point(32'sh8000_0000, 32'sh7FFF_FFFF);
    send_point(coord_t'(3 * FX_ONE / 2), coord_t'(3 * FX_ONE / 2));
    set_limit(count_t'(1));
    send_point(0, 0);
    send_point(coord_t'(2 * FX_ONE), 0);
    send_point(coord_t'(2 * FX_ONE + 1), 0);
    set_limit('1);
    send_point(0, 0);
    send_point(coord_t'(FX_ONE / 4 + FX_ONE / 64), 0);
  endtask

  // Points around the set at the default limit, many of them inside
  task automatic test_deep_dwell();
    set_limit(mbe_pkg::MAX_ITER_RESET);
    repeat (30) send_point(rand_span(-9 * FX_ONE / 4, 3 * FX_ONE),
                           rand_span(-3 * FX_ONE / 2, 3 * FX_ONE));
  endtask

  // No gaps or stalls at all
  task automatic test_back_to_back();
    set_limit(count_t'(16));
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    repeat (60) send_point(rand_span(-9 * FX_ONE / 4, 3 * FX_ONE),
                           rand_span(-3 * FX_ONE / 2, 3 * FX_ONE));
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
  endtask

  // Phases of random points, each under its own limit
  task automatic test_random_points();
    coord_t      re, im;
    longint      rim;
    int unsigned pick;
    for (int ph = 0; ph < 8; ph++) begin
      if (ph % 3 == 2) set_limit(count_t'($urandom_range(255, 49)));
      else             set_limit(count_t'($urandom_range(48, 1)));
      for (int k = 0; k < 50; k++) begin
        pick = $urandom_range(99);
        if (pick < 70) begin
          re = rand_span(-9 * FX_ONE / 4, 3 * FX_ONE);
          im = rand_span(-3 * FX_ONE / 2, 3 * FX_ONE);
        end else if (pick < 85) begin
          re = coord_t'($urandom);
          im = coord_t'($urandom);
        end else begin
          // one component right at +-2
          rim = (pick[0] ? 2 * FX_ONE : -2 * FX_ONE) - 2;
          re  = rand_span(rim, 4);
          im  = rand_span(-FX_ONE / 2, FX_ONE);
          if (pick[1]) begin
            im = re;
            re = rand_span(-FX_ONE / 2, FX_ONE);
          end
        end
        if (ph == 3 && k == 25) wait_drained();
        send_point(re, im);
      end
    end
  endtask

  initial begin
    cfg_we_i            = 1'b0;
    cfg_wdata_i         = '0;
    point_if.valid      = 1'b0;
    point_if.point_real = '0;
    point_if.point_imag = '0;
    limit_model         = mbe_pkg::MAX_ITER_RESET;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_reset_limit();
    test_limit_extremes();
    test_deep_dwell();
    test_back_to_back();
    test_random_points();

    // drain, then watch for stray words
    wait_drained();
    repeat (2 * int'(limit_model) + 8) @(posedge clk_i);
    if (counts_due.size() != 0)
      note_error($sformatf("%0d count words never arrived", counts_due.size()));

    if (error_count == 0) begin
      $display("mandelbrot_escape_time_tb: done, clean");
    end else begin
      $display("mandelbrot_escape_time_tb: done, errors");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/mbe_pkg.sv
hdl/mbe_point_if.sv
hdl/mbe_count_if.sv
hdl/mbe_datapath.sv
hdl/mbe_ctrl.sv
hdl/mandelbrot_escape_time.sv
dv/mandelbrot_escape_time_tb.sv
